// File: hw/rtl/sal_pkg.sv
// sal_pkg: shared types and constants of the suffix array / lcp builder
// used by sal_ctrl, sal_dpath, the top level and its checker; no dependencies
package sal_pkg;

	localparam int MAX_TEXT_DEF = 4096;
	localparam int ALPHABET_DEF = 256;
	localparam int SW = 8;   // text symbol width
	localparam int FW = 12;  // width of the index and result fields

	localparam logic [SW-1:0] SEP_RESET = 8'd35;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DROP = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam int NST = 38;

	typedef enum logic [NST-1:0] {
		S_IDLE   = NST'(1) << 0,
		S_CLR    = NST'(1) << 1,
		S_HIST_A = NST'(1) << 2,
		S_HIST_B = NST'(1) << 3,
		S_HIST_C = NST'(1) << 4,
		S_PS_A   = NST'(1) << 5,
		S_PS_B   = NST'(1) << 6,
		S_DST_A  = NST'(1) << 7,
		S_DST_B  = NST'(1) << 8,
		S_DST_C  = NST'(1) << 9,
		S_R0_A   = NST'(1) << 10,
		S_R0_B   = NST'(1) << 11,
		S_IR_A   = NST'(1) << 12,
		S_IR_B   = NST'(1) << 13,
		S_IR_C   = NST'(1) << 14,
		S_BK_A   = NST'(1) << 15,
		S_BK_B   = NST'(1) << 16,
		S_BK_C   = NST'(1) << 17,
		S_P_A    = NST'(1) << 18,
		S_P_B    = NST'(1) << 19,
		S_P_C    = NST'(1) << 20,
		S_P_D    = NST'(1) << 21,
		S_Q_A    = NST'(1) << 22,
		S_Q_B    = NST'(1) << 23,
		S_Q_C    = NST'(1) << 24,
		S_N0_A   = NST'(1) << 25,
		S_N0_B   = NST'(1) << 26,
		S_N_A    = NST'(1) << 27,
		S_N_B    = NST'(1) << 28,
		S_N_C    = NST'(1) << 29,
		S_N_D    = NST'(1) << 30,
		S_CP_A   = NST'(1) << 31,
		S_CP_B   = NST'(1) << 32,
		S_K_A    = NST'(1) << 33,
		S_K_B    = NST'(1) << 34,
		S_K_C    = NST'(1) << 35,
		S_K_D    = NST'(1) << 36,
		S_K_E    = NST'(1) << 37
	} state_t;

	typedef struct packed {
		state_t op;
		logic   accept;
		logic   finish;
	} sal_cmd_t;

	typedef struct packed {
		logic last_alpha;
		logic last_n;
		logic i_zero;
		logic n_one;
		logic p_skip;
		logic k_more;
		logic top;
		logic k_ok;
		logic ext;
	} sal_flags_t;

endpackage

// File: hw/rtl/sal_ctrl.sv
// sal_ctrl: build sequencer, one-hot state machine stepping the sort, doubling and lcp passes
// depends on sal_pkg; drives sal_dpath through sal_cmd_t and reads its sal_flags_t
module sal_ctrl import sal_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       func,
	input  logic       last_symbol,
	input  sal_flags_t flags,
	output sal_cmd_t   cmd,
	output logic       busy
);

	state_t state_q, state_d;
	logic   accept;
	logic   lcp_next;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// an lcp entry is written and the scan moves to the next position
	always_comb begin
		lcp_next = 1'b0;
		case (state_q)
			S_K_B:   lcp_next = flags.top;
			S_K_D:   lcp_next = !flags.k_ok;
			S_K_E:   lcp_next = !flags.ext;
			default: lcp_next = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (accept && !func && last_symbol) state_d = S_CLR;
			S_CLR:    if (flags.last_alpha) state_d = S_HIST_A;
			S_HIST_A: state_d = S_HIST_B;
			S_HIST_B: state_d = S_HIST_C;
			S_HIST_C: state_d = flags.last_n ? S_PS_A : S_HIST_A;
			S_PS_A:   state_d = S_PS_B;
			S_PS_B:   state_d = flags.last_alpha ? S_DST_A : S_PS_A;
			S_DST_A:  state_d = S_DST_B;
			S_DST_B:  state_d = S_DST_C;
			S_DST_C:  state_d = flags.last_n ? S_R0_A : S_DST_A;
			S_R0_A:   state_d = S_R0_B;
			S_R0_B:   state_d = flags.n_one ? S_BK_A : S_IR_A;
			S_IR_A:   state_d = S_IR_B;
			S_IR_B:   state_d = S_IR_C;
			S_IR_C:   state_d = flags.last_n ? S_BK_A : S_IR_A;
			S_BK_A:   state_d = S_BK_B;
			S_BK_B:   state_d = S_BK_C;
			S_BK_C:   state_d = flags.last_n ? S_P_A : S_BK_A;
			S_P_A:    state_d = S_P_B;
			S_P_B: begin
				if (!flags.p_skip) state_d = S_P_C;
				else state_d = flags.i_zero ? S_Q_A : S_P_A;
			end
			S_P_C:    state_d = S_P_D;
			S_P_D:    state_d = flags.i_zero ? S_Q_A : S_P_A;
			S_Q_A:    state_d = S_Q_B;
			S_Q_B:    state_d = S_Q_C;
			S_Q_C:    state_d = flags.last_n ? S_N0_A : S_Q_A;
			S_N0_A:   state_d = S_N0_B;
			S_N0_B:   state_d = flags.n_one ? S_CP_A : S_N_A;
			S_N_A:    state_d = S_N_B;
			S_N_B:    state_d = S_N_C;
			S_N_C:    state_d = S_N_D;
			S_N_D:    state_d = flags.last_n ? S_CP_A : S_N_A;
			S_CP_A:   state_d = S_CP_B;
			S_CP_B: begin
				if (flags.last_n) state_d = flags.k_more ? S_BK_A : S_K_A;
				else state_d = S_CP_A;
			end
			S_K_A:    state_d = S_K_B;
			S_K_B: begin
				if (flags.top) state_d = flags.last_n ? S_IDLE : S_K_A;
				else state_d = S_K_C;
			end
			S_K_C:    state_d = S_K_D;
			S_K_D: begin
				if (flags.k_ok) state_d = S_K_E;
				else state_d = flags.last_n ? S_IDLE : S_K_A;
			end
			S_K_E: begin
				if (flags.ext) state_d = S_K_D;
				else state_d = flags.last_n ? S_IDLE : S_K_A;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.op     = state_q;
	assign cmd.accept = accept;
	assign cmd.finish = lcp_next && flags.last_n;

endmodule

// File: hw/rtl/sal_dpath.sv
// sal_dpath: text, suffix order, rank, bucket and lcp memories with the working registers
// depends on sal_pkg; sequenced by sal_ctrl, serves load and read items when idle
module sal_dpath import sal_pkg::*; #(
	parameter int MAX_TEXT = MAX_TEXT_DEF,
	parameter int ALPHABET = ALPHABET_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sal_cmd_t      cmd,
	output sal_flags_t    flags,
	input  logic          func,
	input  logic [SW-1:0] symbol,
	input  logic [FW-1:0] query_index,
	input  logic          cfg_we,
	input  logic [SW-1:0] cfg_wdata,
	output logic          done,
	output logic [FW-1:0] suffix_start,
	output logic [FW-1:0] rank_of_position,
	output logic [FW-1:0] common_prefix,
	output logic [1:0]    status
);

	localparam int AW = $clog2(MAX_TEXT);
	localparam int LW = $clog2(MAX_TEXT + 1);
	localparam int KW = LW + 1;
	localparam int NB = (MAX_TEXT > ALPHABET) ? MAX_TEXT : ALPHABET;
	localparam int BW = $clog2(NB);
	localparam int AL = $clog2(ALPHABET + 1);
	localparam int IW = (LW > AL) ? LW : AL;

	// memories
	logic [SW-1:0] txt_mem [MAX_TEXT];
	logic [AW-1:0] sa_mem  [MAX_TEXT];
	logic [AW-1:0] san_mem [MAX_TEXT];
	logic [AW-1:0] rk_mem  [MAX_TEXT];
	logic [AW-1:0] rkn_mem [MAX_TEXT];
	logic [LW-1:0] bkt_mem [NB];
	logic [AW-1:0] lcp_mem [MAX_TEXT];

	logic          txt_we, sa_we, san_we, rk_we, rkn_we, bkt_we, lcp_we;
	logic [AW-1:0] txt_wa, sa_wa, san_wa, rk_wa, rkn_wa, lcp_wa;
	logic [BW-1:0] bkt_wa;
	logic [SW-1:0] txt_wd;
	logic [AW-1:0] sa_wd, san_wd, rk_wd, rkn_wd, lcp_wd;
	logic [LW-1:0] bkt_wd;
	logic [AW-1:0] txt_ra, txt_rb, sa_ra, san_ra, rk_ra, rk_rb, rkn_ra, lcp_ra;
	logic [BW-1:0] bkt_ra;

	logic [SW-1:0] txt_rda_q, txt_rdb_q;
	logic [AW-1:0] sa_rda_q, san_rda_q, rk_rda_q, rk_rdb_q, rkn_rda_q, lcp_rda_q;
	logic [LW-1:0] bkt_rda_q;

	// working registers
	logic [IW-1:0] i_q;
	logic [KW-1:0] k_q;
	logic [LW-1:0] acc_q, carry_q;
	logic [BW-1:0] key_q;
	logic [AW-1:0] val_q, cur_q, prev_q, prank_q, ra_q, rb_q;

	// block state
	logic [LW-1:0] n_q;
	logic          built_q;
	logic [SW-1:0] sep_q;
	logic          done_q, ok_q;
	logic [1:0]    status_q;

	logic [31:0]   n32, i32;
	logic [AW-1:0] qa;
	logic [LW-1:0] nbase;
	logic          full, bad_rd;
	logic [SW-1:0] sym_c;
	logic [LW-1:0] bkt_dec;
	logic [AW-1:0] r_init, r_dbl;
	logic          ak, bk, dinc;
	logic [IW-1:0] i_inc, i_back;
	logic          step;

	assign n32 = 32'(n_q);
	assign i32 = 32'(i_q);
	assign qa  = AW'(query_index);

	assign nbase  = built_q ? '0 : n_q;
	assign full   = (32'(nbase) >= 32'(MAX_TEXT));
	assign sym_c  = (32'(symbol) >= 32'(ALPHABET)) ? SW'(ALPHABET - 1) : symbol;
	assign bad_rd = !built_q || (32'(query_index) >= n32);

	assign bkt_dec = bkt_rda_q - LW'(1);
	assign r_init  = prank_q + AW'(txt_rda_q != txt_rdb_q);
	assign ak      = (32'(cur_q) + 32'(k_q)) < n32;
	assign bk      = (32'(prev_q) + 32'(k_q)) < n32;
	assign dinc    = (ra_q != rb_q) || (ak && !bk) || (ak && bk && (rk_rda_q != rk_rdb_q));
	assign r_dbl   = prank_q + AW'(dinc);

	assign flags.last_alpha = (i32 == 32'(ALPHABET - 1));
	assign flags.last_n     = ((i32 + 32'd1) == n32);
	assign flags.i_zero     = (i_q == '0);
	assign flags.n_one      = (n32 == 32'd1);
	assign flags.p_skip     = (32'(sa_rda_q) < 32'(k_q));
	assign flags.k_more     = ((32'(k_q) << 1) <= n32);
	assign flags.top        = ((32'(rk_rda_q) + 32'd1) >= n32);
	assign flags.k_ok       = ((i32 + 32'(carry_q)) < n32) &&
	                          ((32'(cur_q) + 32'(carry_q)) < n32);
	assign flags.ext        = (txt_rda_q == txt_rdb_q) && (txt_rda_q != sep_q);

	assign i_inc  = flags.last_n ? '0 : i_q + IW'(1);
	assign i_back = flags.i_zero ? IW'(32'(n_q) - 32'(k_q)) : i_q - IW'(1);

	// kasai: this cycle closes the current position
	always_comb begin
		case (cmd.op)
			S_K_B:   step = flags.top;
			S_K_D:   step = !flags.k_ok;
			S_K_E:   step = !flags.ext;
			default: step = 1'b0;
		endcase
	end

	// memory port selection
	always_comb begin
		txt_we = 1'b0; txt_wa = AW'(nbase); txt_wd = sym_c;
		sa_we  = 1'b0; sa_wa  = AW'(bkt_dec); sa_wd = AW'(i_q);
		san_we = 1'b0; san_wa = AW'(bkt_dec); san_wd = val_q;
		rk_we  = 1'b0; rk_wa  = AW'(i_q); rk_wd = rkn_rda_q;
		rkn_we = 1'b0; rkn_wa = cur_q; rkn_wd = r_dbl;
		bkt_we = 1'b0; bkt_wa = key_q; bkt_wd = bkt_dec;
		lcp_we = 1'b0; lcp_wa = AW'(i_q); lcp_wd = AW'(carry_q);
		txt_ra = AW'(i_q); txt_rb = prev_q;
		sa_ra  = qa; san_ra = AW'(i_q);
		rk_ra  = qa; rk_rb  = prev_q;
		rkn_ra = AW'(i_q); lcp_ra = qa;
		bkt_ra = BW'(i_q);
		case (cmd.op)
			S_IDLE: begin
				txt_we = cmd.accept && !func && !full;
			end
			S_CLR: begin
				bkt_we = 1'b1; bkt_wa = BW'(i_q); bkt_wd = '0;
			end
			S_HIST_B, S_DST_B: begin
				bkt_ra = BW'(txt_rda_q);
			end
			S_HIST_C: begin
				bkt_we = 1'b1; bkt_wd = bkt_rda_q + LW'(1);
			end
			S_PS_B: begin
				bkt_we = 1'b1; bkt_wa = BW'(i_q); bkt_wd = acc_q + bkt_rda_q;
			end
			S_DST_C: begin
				bkt_we = 1'b1; sa_we = 1'b1;
			end
			S_R0_A: begin
				sa_ra = '0;
			end
			S_R0_B: begin
				rk_we = 1'b1; rk_wa = sa_rda_q; rk_wd = '0;
			end
			S_IR_A, S_BK_A, S_P_A: begin
				sa_ra = AW'(i_q);
			end
			S_IR_B: begin
				txt_ra = sa_rda_q; txt_rb = prev_q;
			end
			S_IR_C: begin
				rk_we = 1'b1; rk_wa = cur_q; rk_wd = r_init;
			end
			S_BK_B: begin
				rk_ra = sa_rda_q;
			end
			S_BK_C: begin
				bkt_we = 1'b1; bkt_wa = BW'(rk_rda_q); bkt_wd = LW'(i32 + 32'd1);
			end
			S_P_B: begin
				rk_ra = AW'(32'(sa_rda_q) - 32'(k_q));
			end
			S_P_C, S_Q_B: begin
				bkt_ra = BW'(rk_rda_q);
			end
			S_P_D: begin
				bkt_we = 1'b1; san_we = 1'b1;
			end
			S_Q_A, S_K_A: begin
				rk_ra = AW'(i_q);
			end
			S_Q_C: begin
				bkt_we = 1'b1; san_we = 1'b1; san_wd = AW'(i_q);
			end
			S_N0_A: begin
				san_ra = '0;
			end
			S_N0_B: begin
				rkn_we = 1'b1; rkn_wa = san_rda_q; rkn_wd = '0;
			end
			S_N_B: begin
				rk_ra = san_rda_q; rk_rb = prev_q;
			end
			S_N_C: begin
				rk_ra = AW'(32'(cur_q) + 32'(k_q));
				rk_rb = AW'(32'(prev_q) + 32'(k_q));
			end
			S_N_D: begin
				rkn_we = 1'b1;
			end
			S_CP_B: begin
				rk_we = 1'b1; sa_we = 1'b1; sa_wa = AW'(i_q); sa_wd = san_rda_q;
			end
			S_K_B: begin
				sa_ra = AW'(32'(rk_rda_q) + 32'd1);
				lcp_we = flags.top; lcp_wd = '0;
			end
			S_K_D: begin
				txt_ra = AW'(i32 + 32'(carry_q));
				txt_rb = AW'(32'(cur_q) + 32'(carry_q));
				lcp_we = step;
			end
			S_K_E: begin
				lcp_we = step;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (txt_we) txt_mem[txt_wa] <= txt_wd;
		txt_rda_q <= txt_mem[txt_ra];
		txt_rdb_q <= txt_mem[txt_rb];
	end

	always_ff @(posedge clk) begin
		if (sa_we) sa_mem[sa_wa] <= sa_wd;
		sa_rda_q <= sa_mem[sa_ra];
	end

	always_ff @(posedge clk) begin
		if (san_we) san_mem[san_wa] <= san_wd;
		san_rda_q <= san_mem[san_ra];
	end

	always_ff @(posedge clk) begin
		if (rk_we) rk_mem[rk_wa] <= rk_wd;
		rk_rda_q <= rk_mem[rk_ra];
		rk_rdb_q <= rk_mem[rk_rb];
	end

	always_ff @(posedge clk) begin
		if (rkn_we) rkn_mem[rkn_wa] <= rkn_wd;
		rkn_rda_q <= rkn_mem[rkn_ra];
	end

	always_ff @(posedge clk) begin
		if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
		bkt_rda_q <= bkt_mem[bkt_ra];
	end

	always_ff @(posedge clk) begin
		if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
		lcp_rda_q <= lcp_mem[lcp_ra];
	end

	// loop counters and scratch registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			// the bucket clear starts from index zero
			S_IDLE: i_q <= '0;
			S_CLR: begin
				i_q   <= flags.last_alpha ? '0 : i_q + IW'(1);
				acc_q <= '0;
			end
			S_HIST_B, S_DST_B: key_q <= BW'(txt_rda_q);
			S_HIST_C, S_DST_C, S_IR_C, S_Q_C, S_CP_B, S_N_D: begin
				i_q <= i_inc;
				if (cmd.op == S_IR_C) begin
					prev_q  <= cur_q;
					prank_q <= r_init;
				end
				if (cmd.op == S_N_D) begin
					prev_q  <= cur_q;
					prank_q <= r_dbl;
				end
				if (cmd.op == S_CP_B && flags.last_n) begin
					k_q     <= k_q << 1;
					carry_q <= '0;
				end
			end
			S_PS_B: begin
				i_q   <= flags.last_alpha ? '0 : i_q + IW'(1);
				acc_q <= acc_q + bkt_rda_q;
			end
			S_R0_B: begin
				i_q     <= flags.n_one ? '0 : IW'(1);
				k_q     <= KW'(1);
				prev_q  <= sa_rda_q;
				prank_q <= '0;
			end
			S_IR_B: cur_q <= sa_rda_q;
			S_BK_C: i_q <= flags.last_n ? IW'(32'(n_q) - 32'd1) : i_q + IW'(1);
			S_P_B: begin
				val_q <= AW'(32'(sa_rda_q) - 32'(k_q));
				if (flags.p_skip) i_q <= i_back;
			end
			S_P_C, S_Q_B: key_q <= BW'(rk_rda_q);
			S_P_D: i_q <= i_back;
			S_N0_B: begin
				i_q     <= flags.n_one ? '0 : IW'(1);
				prev_q  <= san_rda_q;
				prank_q <= '0;
			end
			S_N_B: cur_q <= san_rda_q;
			S_N_C: begin
				ra_q <= rk_rda_q;
				rb_q <= rk_rdb_q;
			end
			S_K_B: begin
				if (flags.top) begin
					carry_q <= '0;
					i_q     <= i_inc;
				end else if (carry_q != '0) begin
					carry_q <= carry_q - LW'(1);
				end
			end
			S_K_C: cur_q <= sa_rda_q;
			S_K_D: if (step) i_q <= i_inc;
			S_K_E: begin
				if (flags.ext) carry_q <= carry_q + LW'(1);
				else i_q <= i_inc;
			end
			default: ;
		endcase
	end

	// text length, build flag, separator and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			built_q  <= 1'b0;
			sep_q    <= SEP_RESET;
			done_q   <= 1'b0;
			ok_q     <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (cfg_we) sep_q <= cfg_wdata;
			done_q <= cmd.accept;
			ok_q   <= 1'b0;
			if (cmd.accept) begin
				if (!func) begin
					built_q  <= 1'b0;
					n_q      <= full ? nbase : nbase + LW'(1);
					status_q <= full ? ST_DROP : ST_OK;
				end else begin
					ok_q     <= !bad_rd;
					status_q <= bad_rd ? ST_BAD : ST_OK;
				end
			end
			if (cmd.finish) built_q <= 1'b1;
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign suffix_start     = ok_q ? FW'(sa_rda_q) : '0;
	assign rank_of_position = ok_q ? FW'(rk_rda_q) : '0;
	assign common_prefix    = ok_q ? FW'(lcp_rda_q) : '0;

endmodule

// File: hw/rtl/suffix_array_lcp_builder.sv
// channel   direction  handshake                    payload
// item      in         start & !busy                func, symbol, last_symbol, query_index
// result    out        done, one cycle, no stall    suffix_start, rank_of_position,
//                                                   common_prefix, status
// config    in         cfg_we                       cfg_wdata (separator byte)
//
// loads and reads: one item per cycle while idle, the result follows in the next cycle.
// a load with last_symbol set starts the build; busy stays high through the sort and
//   doubling passes and then the lcp pass, every element step waiting on one registered
//   memory read at a time.
// reset clears the text length, the built flag and sets the separator to '#'.
// results are never held back: done lasts exactly one cycle.
// top level of the suffix array / lcp builder; depends on sal_pkg, sal_ctrl, sal_dpath
module suffix_array_lcp_builder import sal_pkg::*; #(
	parameter int MAX_TEXT = MAX_TEXT_DEF,
	parameter int ALPHABET = ALPHABET_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic          func,
	input  logic [SW-1:0] symbol,
	input  logic          last_symbol,
	input  logic [FW-1:0] query_index,
	output logic          done,
	output logic [FW-1:0] suffix_start,
	output logic [FW-1:0] rank_of_position,
	output logic [FW-1:0] common_prefix,
	output logic [1:0]    status,
	input  logic          cfg_we,
	input  logic [SW-1:0] cfg_wdata
);

	sal_cmd_t   cmd;
	sal_flags_t flags;

	sal_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func),
		.last_symbol (last_symbol),
		.flags       (flags),
		.cmd         (cmd),
		.busy        (busy)
	);

	sal_dpath #(
		.MAX_TEXT (MAX_TEXT),
		.ALPHABET (ALPHABET)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.flags            (flags),
		.func             (func),
		.symbol           (symbol),
		.query_index      (query_index),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.done             (done),
		.suffix_start     (suffix_start),
		.rank_of_position (rank_of_position),
		.common_prefix    (common_prefix),
		.status           (status)
	);

endmodule

// File: hw/rtl/sal_checker.sv
// sal_checker: port-level checks of the suffix array / lcp builder, bound to the top level
// depends on sal_pkg
module sal_checker import sal_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          func,
	input logic          done,
	input logic [FW-1:0] suffix_start,
	input logic [FW-1:0] rank_of_position,
	input logic [FW-1:0] common_prefix,
	input logic [1:0]    status
);

	// every accepted item gets its result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("no result after accepted item");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without accepted item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_DROP || status == ST_BAD))
		else $error("illegal status");

	// loads and failed reads carry zero fields
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK || !$past(func)) |->
		suffix_start == '0 && rank_of_position == '0 && common_prefix == '0)
		else $error("nonzero fields on load or failed read");

endmodule

bind suffix_array_lcp_builder sal_checker u_sal_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for suffix_array_lcp_builder: drives load and read items with random gaps and
// checks every result against a built-in suffix array / rank / lcp predictor
// depends on sal_pkg and the rtl of suffix_array_lcp_builder
module testbench;
	import sal_pkg::*;

	localparam int NTXT = MAX_TEXT_DEF;
	localparam int NBKT = MAX_TEXT_DEF + ALPHABET_DEF;
	localparam int STALL_LIMIT = 3000000;

	typedef struct packed {
		logic [FW-1:0] sa;
		logic [FW-1:0] rk;
		logic [FW-1:0] lcp;
		logic [1:0]    st;
	} result_t;

	typedef struct {
		bit          fn;
		logic [7:0]  sym;
		bit          last;
		int unsigned q;
		bit          typed;
		logic [1:0]  st;
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic          func;
	logic [SW-1:0] symbol;
	logic          last_symbol;
	logic [FW-1:0] query_index;
	logic          done;
	logic [FW-1:0] suffix_start;
	logic [FW-1:0] rank_of_position;
	logic [FW-1:0] common_prefix;
	logic [1:0]    status;
	logic          cfg_we;
	logic [SW-1:0] cfg_wdata;

	suffix_array_lcp_builder u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .symbol(symbol), .last_symbol(last_symbol), .query_index(query_index),
		.done(done), .suffix_start(suffix_start), .rank_of_position(rank_of_position),
		.common_prefix(common_prefix), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state
	logic [7:0]  txt [NTXT];
	int unsigned sa_cur [NTXT];
	int unsigned sa_nxt [NTXT];
	int unsigned rk_cur [NTXT];
	int unsigned rk_nxt [NTXT];
	int unsigned bkt [NBKT];
	int unsigned lcp_tab [NTXT];
	int unsigned txt_len;
	bit          is_built;
	logic [7:0]  sep_byte;

	result_t pending_results[$];
	int      err_count;
	int      mismatch_count;
	int      item_count;
	int      stall_cnt;
	bit      burst;

	function automatic int unsigned bclamp(int unsigned v);
		return v < NBKT ? v : NBKT - 1;
	endfunction

	function automatic int unsigned tclamp(int unsigned v);
		return v < NTXT ? v : NTXT - 1;
	endfunction

	// bucket slot decrement, then place val into the current or next suffix order
	function automatic void bucket_place(bit to_next, int unsigned key, int unsigned val);
		int unsigned b;
		b = bclamp(key);
		bkt[b] = bkt[b] - 1;
		if (to_next)
			sa_nxt[tclamp(bkt[b])] = val;
		else
			sa_cur[tclamp(bkt[b])] = val;
	endfunction

	function automatic void build_tables();
		int unsigned n, i, k, carry, a, b, r, p, j;
		int          ii;
		n = txt_len;
		if (n == 0) return;
		foreach (bkt[x]) bkt[x] = 0;
		for (i = 0; i < n; i++) bkt[txt[i]] = bkt[txt[i]] + 1;
		for (i = 1; i < ALPHABET_DEF; i++) bkt[i] = bkt[i] + bkt[i-1];
		for (i = 0; i < n; i++) bucket_place(1'b0, txt[i], i);
		rk_cur[tclamp(sa_cur[0])] = 0;
		for (i = 1; i < n; i++) begin
			a = tclamp(sa_cur[i]);
			b = tclamp(sa_cur[i-1]);
			rk_cur[a] = rk_cur[b] + ((txt[a] != txt[b]) ? 1 : 0);
		end
		for (k = 1; k <= n; k = k << 1) begin
			for (i = 0; i < n; i++) bkt[bclamp(rk_cur[tclamp(sa_cur[i])])] = i + 1;
			for (ii = n - 1; ii >= 0; ii--) begin
				p = sa_cur[ii];
				if (p >= k) bucket_place(1'b1, rk_cur[tclamp(p - k)], p - k);
			end
			for (i = n - k; i < n; i++) bucket_place(1'b1, rk_cur[i], i);
			rk_nxt[tclamp(sa_nxt[0])] = 0;
			for (i = 1; i < n; i++) begin
				a = tclamp(sa_nxt[i]);
				b = tclamp(sa_nxt[i-1]);
				r = rk_nxt[b];
				if (rk_cur[a] != rk_cur[b]) r++;
				else if (a + k < n && b + k >= n) r++;
				else if (a + k < n && b + k < n && rk_cur[a+k] != rk_cur[b+k]) r++;
				rk_nxt[a] = r;
			end
			rk_cur = rk_nxt;
			sa_cur = sa_nxt;
		end
		// kasai pass; comparison stops on the separator byte
		carry = 0;
		for (i = 0; i < n; i++) begin
			r = rk_cur[i];
			if (r + 1 >= n) begin
				lcp_tab[i] = 0;
				carry = 0;
			end else begin
				if (carry > 0) carry--;
				j = sa_cur[tclamp(r + 1)];
				while (i + carry < n && j + carry < n && txt[i+carry] == txt[tclamp(j+carry)]
					&& txt[i+carry] != sep_byte)
					carry++;
				lcp_tab[i] = carry;
			end
		end
	endfunction

	function automatic result_t predict_result(bit fn, logic [7:0] sym, bit last,
		int unsigned q);
		result_t res;
		res = '0;
		res.st = ST_OK;
		if (!fn) begin
			if (is_built) begin
				txt_len = 0;
				is_built = 0;
			end
			if (txt_len < NTXT) begin
				txt[txt_len] = sym;
				txt_len++;
			end else begin
				res.st = ST_DROP;
			end
			if (last) begin
				build_tables();
				is_built = 1;
			end
		end else if (!is_built || q >= txt_len) begin
			res.st = ST_BAD;
		end else begin
			res.sa = sa_cur[q][FW-1:0];
			res.rk = rk_cur[q][FW-1:0];
			res.lcp = lcp_tab[q][FW-1:0];
		end
		return res;
	endfunction

	// drive one item and hold it until the block takes it
	task automatic send_item(bit fn, logic [7:0] sym, bit last, int unsigned q,
		bit typed = 0, logic [1:0] st = ST_OK);
		result_t res;
		int      gap;
		start <= 1'b1;
		func <= fn;
		symbol <= sym;
		last_symbol <= last;
		query_index <= q[FW-1:0];
		do @(posedge clk); while (busy);
		res = predict_result(fn, sym, last, q);
		if (typed) begin
			res = '0;
			res.st = st;
		end
		pending_results.push_back(res);
		item_count++;
		if ($urandom_range(0, 49) == 0) burst = !burst;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_separator(logic [7:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sep_byte = v;
	endtask

	task automatic random_phase(int target);
		int          n, m, i, mode;
		int unsigned q;
		logic [7:0]  sym;
		while (item_count < target) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
			mode = $urandom_range(0, 3);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 7) == 0)
					sym = sep_byte;
				else if (mode == 0)
					sym = $urandom_range(0, 255);
				else
					sym = 8'h61 + $urandom_range(0, mode);
				// a read in the middle of a text sees no finished build
				if (i > 0 && $urandom_range(0, 30) == 0)
					send_item(1'b1, $urandom_range(0, 255), $urandom_range(0, 1),
						$urandom_range(0, n));
				send_item(1'b0, sym, i == n - 1, $urandom_range(0, 4095));
			end
			m = $urandom_range(1, n + 3);
			for (i = 0; i < m; i++) begin
				q = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, n);
				send_item(1'b1, $urandom_range(0, 255), $urandom_range(0, 1), q);
			end
		end
	endtask

	// result checker and stall watchdog
	always @(posedge clk) begin
		result_t got, want;
		if (done || (start && !busy))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else if (arst_n && done) begin
			got = {suffix_start, rank_of_position, common_prefix, status};
			if (pending_results.size() == 0) begin
				err_count <= err_count + 1;
				if (mismatch_count < 10)
					$display("%0t: result with none pending: %p", $realtime, got);
				mismatch_count <= mismatch_count + 1;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					err_count <= err_count + 1;
					if (mismatch_count < 10)
						$display("%0t: mismatch sa %0d/%0d rank %0d/%0d lcp %0d/%0d st %0d/%0d",
							$realtime, want.sa, got.sa, want.rk, got.rk, want.lcp, got.lcp,
							want.st, got.st);
					mismatch_count <= mismatch_count + 1;
				end
			end
		end
	end

	row_t rows[$];

	initial begin
		int i;
		arst_n = 1'b0;
		start = 1'b0;
		func = 1'b0;
		symbol = '0;
		last_symbol = 1'b0;
		query_index = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		err_count = 0;
		mismatch_count = 0;
		item_count = 0;
		stall_cnt = 0;
		burst = 0;
		txt_len = 0;
		is_built = 0;
		sep_byte = SEP_RESET;
		foreach (txt[x]) txt[x] = 0;
		foreach (sa_cur[x]) begin
			sa_cur[x] = 0; sa_nxt[x] = 0; rk_cur[x] = 0; rk_nxt[x] = 0; lcp_tab[x] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads before any build, then a short text holding the separator and both byte extremes
		rows.push_back('{1, 8'hFF, 1, 0, 1, ST_BAD});
		rows.push_back('{1, 8'h00, 0, 4095, 1, ST_BAD});
		rows.push_back('{0, 8'h61, 0, 4095, 1, ST_OK});
		rows.push_back('{0, 8'h62, 0, 0, 1, ST_OK});
		rows.push_back('{0, 8'h23, 0, 0, 1, ST_OK});
		rows.push_back('{0, 8'h61, 0, 0, 1, ST_OK});
		rows.push_back('{0, 8'h62, 0, 0, 1, ST_OK});
		rows.push_back('{0, 8'h00, 0, 0, 1, ST_OK});
		rows.push_back('{0, 8'hFF, 1, 0, 1, ST_OK});
		for (i = 0; i < 7; i++) rows.push_back('{1, 8'h00, 0, i, 0, ST_OK});
		rows.push_back('{1, 8'h00, 0, 7, 1, ST_BAD});
		rows.push_back('{1, 8'hFF, 1, 4095, 1, ST_BAD});
		rows.push_back('{0, 8'h7A, 1, 0, 1, ST_OK});   // single byte text
		rows.push_back('{1, 8'h00, 0, 0, 0, ST_OK});
		rows.push_back('{1, 8'h00, 0, 1, 1, ST_BAD});
		foreach (rows[r])
			send_item(rows[r].fn, rows[r].sym, rows[r].last, rows[r].q, rows[r].typed, rows[r].st);

		// fill the store to capacity; the extra byte is dropped but still builds
		for (i = 0; i < NTXT; i++)
			send_item(1'b0, $urandom_range(0, 255), 1'b0, $urandom_range(0, 4095));
		send_item(1'b0, 8'h41, 1'b1, 0, 1'b1, ST_DROP);
		for (i = 0; i < 12; i++)
			send_item(1'b1, 8'h00, 1'b0, (i < 2) ? 4095 - i : $urandom_range(0, 4095));
		send_item(1'b1, 8'h00, 1'b0, 0);
		item_count = 0;

		write_separator(8'h00);
		random_phase(330);
		write_separator(8'hFF);
		random_phase(660);
		write_separator(8'h61);
		random_phase(990);
		write_separator($urandom_range(0, 255));
		random_phase(1320);
		write_separator(SEP_RESET);
		random_phase(1650);

		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
